// File: design/bhpq_pkg.sv
`default_nettype none
package bhpq_pkg;
   localparam int CAPACITY      = 256;
   localparam int PRIORITY_BITS = 16;
   localparam int VALUE_BITS    = 32;
   localparam int HANDLE_BITS   = 8;
   localparam int COUNT_BITS    = 9;

   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_INSERT   = 2'd0;
   localparam req_code_type REQ_REMOVE   = 2'd1;
   localparam req_code_type REQ_UPDATE   = 2'd2;
   localparam req_code_type REQ_CONTAINS = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_EMPTY  = 2'd1;
   localparam status_type ST_FULL   = 2'd2;
   localparam status_type ST_NOHDL  = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FREE,      // scan in_use for lowest free handle
      S_UP_RD,     // read parent slot handle
      S_UP_RP,     // read parent priority
      S_UP_CMP,
      S_UD_RD,     // update: read position
      S_UD_WAIT,
      S_RM_RD,     // remove: read root handle
      S_RM_RL,
      S_RM_RP,     // read priority of moved entry
      S_DN_RL,     // read left child handle
      S_DN_RR,     // read right child handle
      S_DN_PL,     // left priority
      S_DN_PR,     // right priority
      S_DN_CMP,
      S_CT_RD,
      S_CT_RV,
      S_CT_CMP,
      S_TOP_RH,
      S_TOP_RD,
      S_TOP_OUT
   } state_type;
endpackage
`default_nettype wire

// File: design/bhpq_ram.sv
`default_nettype none
module bhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: design/binary_heap_priority_queue.sv
`default_nettype none
// channel  | ports                         | handshake
// request  | req_type, entry_*, start      | accepted when start & !busy
// response | rsp_*                         | rsp_valid one cycle, no stall
// config   | csr_we, csr_wdata             | written when csr_we
// Insert: free-handle search (one handle a cycle), then UP_RD..UP_CMP per level.
// Remove: DN_RL..DN_CMP each level. Contains: CT_RD, CT_RV, CT_CMP each entry.
// Each request ends by reading the root (TOP_RH..TOP_OUT); busy is high throughout.
// Reset clears the in-use flags (flip-flops) and the count; memories are not cleared.
module binary_heap_priority_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [1:0]   req_type,
   input  wire logic [15:0]  req_entry_priority,
   input  wire logic [31:0]  req_entry_value,
   input  wire logic [7:0]   req_entry_handle,
   input  wire logic         csr_we,
   input  wire logic         csr_wdata,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_new_handle,
   output logic              rsp_found,
   output logic              rsp_top_valid,
   output logic [15:0]       rsp_top_priority,
   output logic [31:0]       rsp_top_value,
   output logic [7:0]        rsp_top_handle,
   output logic [8:0]        rsp_entry_count
);
   import bhpq_pkg::*;

   localparam int AW = HANDLE_BITS;

   state_type state_ff, state_in;
   logic                  order_ff;
   logic [CAPACITY-1:0]   in_use_ff, in_use_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [AW-1:0]         hdl_ff, hdl_in;     // moving handle
   logic [PRIORITY_BITS-1:0] hprio_ff, hprio_in;
   logic [COUNT_BITS-1:0] pos_ff, pos_in;     // current position
   logic [AW-1:0]         ch_ff, ch_in;       // candidate handle (parent/left/child)
   logic [AW-1:0]         rh_ff, rh_in;       // right child handle
   logic [PRIORITY_BITS-1:0] cp_ff, cp_in;    // candidate priority
   logic [PRIORITY_BITS-1:0] lp_ff, lp_in;
   logic [1:0]            status_ff, status_in;
   logic [AW-1:0]         newh_ff, newh_in;
   logic                  found_ff, found_in;
   logic                  rv_ff, rv_in;
   logic [PRIORITY_BITS-1:0] tp_ff, tp_in;
   logic [VALUE_BITS-1:0] tv_ff, tv_in;
   logic [AW-1:0]         th_ff, th_in;

   // heap_order
   logic ho_we; logic [AW-1:0] ho_wa, ho_wd, ho_ra, ho_rd;
   // slot_position
   logic sp_we; logic [AW-1:0] sp_wa, sp_wd, sp_ra, sp_rd;
   // slot_priority
   logic pr_we; logic [AW-1:0] pr_wa, pr_ra;
   logic [PRIORITY_BITS-1:0] pr_wd, pr_rd;
   // slot_value
   logic vl_we; logic [AW-1:0] vl_wa, vl_ra;
   logic [VALUE_BITS-1:0] vl_wd, vl_rd;

   bhpq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_order (
      .clock, .wr_en(ho_we), .wr_addr(ho_wa), .wr_data(ho_wd), .rd_addr(ho_ra), .rd_data(ho_rd));
   bhpq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_pos (
      .clock, .wr_en(sp_we), .wr_addr(sp_wa), .wr_data(sp_wd), .rd_addr(sp_ra), .rd_data(sp_rd));
   bhpq_ram #(.WIDTH(PRIORITY_BITS), .DEPTH(CAPACITY)) u_prio (
      .clock, .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(pr_wd), .rd_addr(pr_ra), .rd_data(pr_rd));
   bhpq_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
      .clock, .wr_en(vl_we), .wr_addr(vl_wa), .wr_data(vl_wd), .rd_addr(vl_ra), .rd_data(vl_rd));

   function automatic logic worse(input logic ord, input logic [PRIORITY_BITS-1:0] a,
                                  input logic [PRIORITY_BITS-1:0] b);
      worse = ord ? (a < b) : (a > b);
   endfunction

   logic [COUNT_BITS-1:0] parent_pos, left_pos, right_pos;
   logic                  take_right;
   logic [AW-1:0]         best_h;
   logic [PRIORITY_BITS-1:0] best_p;
   logic [COUNT_BITS-1:0] best_pos;

   always_comb begin
      parent_pos = (pos_ff - COUNT_BITS'(1)) >> 1;
      left_pos   = COUNT_BITS'({pos_ff, 1'b1});
      right_pos  = left_pos + COUNT_BITS'(1);
      take_right = (right_pos < count_ff) && !worse(order_ff, cp_ff, lp_ff);
      best_h     = take_right ? rh_ff : ch_ff;
      best_p     = take_right ? cp_ff : lp_ff;
      best_pos   = take_right ? right_pos : left_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         order_ff  <= 1'b0;
         in_use_ff <= '0;
         count_ff  <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_use_ff <= in_use_in;
         count_ff  <= count_in;
         rv_ff     <= rv_in;
         if (csr_we) begin
            order_ff <= csr_wdata;
         end
      end
      prio_ff <= prio_in; val_ff <= val_in; hdl_ff <= hdl_in;
      hprio_ff <= hprio_in; pos_ff <= pos_in; ch_ff <= ch_in; rh_ff <= rh_in;
      cp_ff <= cp_in; lp_ff <= lp_in; status_ff <= status_in; newh_ff <= newh_in;
      found_ff <= found_in; tp_ff <= tp_in; tv_ff <= tv_in; th_ff <= th_in;
   end

   always_comb begin
      state_in = state_ff;
      in_use_in = in_use_ff; count_in = count_ff;
      prio_in = prio_ff; val_in = val_ff; hdl_in = hdl_ff;
      hprio_in = hprio_ff; pos_in = pos_ff; ch_in = ch_ff; rh_in = rh_ff;
      cp_in = cp_ff; lp_in = lp_ff; status_in = status_ff; newh_in = newh_ff;
      found_in = found_ff; tp_in = tp_ff; tv_in = tv_ff; th_in = th_ff;
      rv_in = 1'b0;
      ho_we = 1'b0; ho_wa = pos_ff[AW-1:0]; ho_wd = hdl_ff; ho_ra = '0;
      sp_we = 1'b0; sp_wa = hdl_ff; sp_wd = pos_ff[AW-1:0]; sp_ra = hdl_ff;
      pr_we = 1'b0; pr_wa = hdl_ff; pr_wd = prio_ff; pr_ra = hdl_ff;
      vl_we = 1'b0; vl_wa = hdl_ff; vl_wd = val_ff; vl_ra = hdl_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               prio_in = req_entry_priority; val_in = req_entry_value;
               hdl_in = '0; status_in = ST_OK; newh_in = '0; found_in = 1'b0;
               pos_in = '0;
               unique case (req_type)
                  REQ_INSERT: begin
                     if (count_ff >= COUNT_BITS'(CAPACITY)) begin
                        status_in = ST_FULL; state_in = S_TOP_RH;
                     end else begin
                        state_in = S_FREE;
                     end
                  end
                  REQ_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY; state_in = S_TOP_RH;
                     end else begin
                        state_in = S_RM_RD;
                     end
                  end
                  REQ_UPDATE: begin
                     hdl_in = req_entry_handle;
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY; state_in = S_TOP_RH;
                     end else if (!in_use_ff[req_entry_handle]) begin
                        status_in = ST_NOHDL; state_in = S_TOP_RH;
                     end else begin
                        state_in = S_UD_RD;
                     end
                  end
                  REQ_CONTAINS: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY; state_in = S_TOP_RH;
                     end else begin
                        state_in = S_CT_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FREE: begin
            if (!in_use_ff[hdl_ff]) begin
               in_use_in[hdl_ff] = 1'b1;
               pr_we = 1'b1; vl_we = 1'b1;
               newh_in = hdl_ff; hprio_in = prio_ff;
               pos_in = count_ff;
               count_in = count_ff + COUNT_BITS'(1);
               state_in = S_UP_RD;
            end else begin
               hdl_in = hdl_ff + AW'(1);
            end
         end
         S_UD_RD: begin
            pr_we = 1'b1; vl_we = 1'b1; hprio_in = prio_ff;
            sp_ra = hdl_ff;
            state_in = S_UD_WAIT;
         end
         S_UD_WAIT: begin
            pos_in = COUNT_BITS'(sp_rd);
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               ho_we = 1'b1; sp_we = 1'b1;
               state_in = S_TOP_RH;
            end else begin
               ho_ra = parent_pos[AW-1:0];
               state_in = S_UP_RP;
            end
         end
         S_UP_RP: begin
            ch_in = ho_rd; pr_ra = ho_rd;
            state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            if (worse(order_ff, pr_rd, hprio_ff)) begin
               ho_we = 1'b1; ho_wd = ch_ff;
               sp_we = 1'b1; sp_wa = ch_ff;
               pos_in = parent_pos;
               state_in = S_UP_RD;
            end else begin
               ho_we = 1'b1; sp_we = 1'b1;
               state_in = S_TOP_RH;
            end
         end
         S_RM_RD: begin
            ho_ra = '0;
            state_in = S_RM_RL;
         end
         S_RM_RL: begin
            in_use_in[ho_rd] = 1'b0;
            count_in = count_ff - COUNT_BITS'(1);
            ho_ra = count_in[AW-1:0];
            if (count_in == '0) begin
               state_in = S_TOP_RH;
            end else begin
               state_in = S_RM_RP;
            end
         end
         S_RM_RP: begin
            hdl_in = ho_rd; pr_ra = ho_rd; pos_in = '0;
            state_in = S_DN_RL;
         end
         S_DN_RL: begin
            // first step at the root: moved entry's priority arrives now
            if (pos_ff == '0) begin
               hprio_in = pr_rd;
            end
            ho_ra = left_pos[AW-1:0];
            if (left_pos >= count_ff) begin
               ho_we = 1'b1; sp_we = 1'b1;
               state_in = S_TOP_RH;
            end else begin
               state_in = S_DN_RR;
            end
         end
         S_DN_RR: begin
            ch_in = ho_rd; pr_ra = ho_rd;
            ho_ra = right_pos[AW-1:0];
            state_in = S_DN_PL;
         end
         S_DN_PL: begin
            lp_in = pr_rd; rh_in = ho_rd; pr_ra = ho_rd;
            state_in = S_DN_PR;
         end
         S_DN_PR: begin
            cp_in = pr_rd;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (worse(order_ff, hprio_ff, best_p)) begin
               ho_we = 1'b1; ho_wd = best_h;
               sp_we = 1'b1; sp_wa = best_h;
               pos_in = best_pos;
               state_in = S_DN_RL;
            end else begin
               ho_we = 1'b1; sp_we = 1'b1;
               state_in = S_TOP_RH;
            end
         end
         S_CT_RD: begin
            ho_ra = pos_ff[AW-1:0];
            state_in = S_CT_RV;
         end
         S_CT_RV: begin
            vl_ra = ho_rd;
            state_in = S_CT_CMP;
         end
         S_CT_CMP: begin
            if (vl_rd == val_ff) begin
               found_in = 1'b1; state_in = S_TOP_RH;
            end else if (pos_ff + COUNT_BITS'(1) >= count_ff) begin
               state_in = S_TOP_RH;
            end else begin
               pos_in = pos_ff + COUNT_BITS'(1);
               state_in = S_CT_RD;
            end
         end
         S_TOP_RH: begin
            ho_ra = '0;
            state_in = S_TOP_RD;
         end
         S_TOP_RD: begin
            th_in = ho_rd; pr_ra = ho_rd; vl_ra = ho_rd;
            state_in = S_TOP_OUT;
         end
         S_TOP_OUT: begin
            tp_in = pr_rd; tv_in = vl_rd;
            if (count_ff == '0) begin
               th_in = '0; tp_in = '0; tv_in = '0;
            end
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != S_IDLE);
   end

   assign rsp_valid        = rv_ff;
   assign rsp_status       = status_ff;
   assign rsp_new_handle   = newh_ff;
   assign rsp_found        = found_ff;
   assign rsp_top_valid    = (count_ff != '0);
   assign rsp_top_priority = tp_ff;
   assign rsp_top_value    = tv_ff;
   assign rsp_top_handle   = th_ff;
   assign rsp_entry_count  = count_ff;
endmodule
`default_nettype wire
